// ===== sv/ctclfr_pkg.sv =====
// Shared types, constants and arithmetic helpers of the CTC log forward recurrence.
`default_nettype none

package ctclfr_pkg;

    localparam int VAL_W          = 24;
    localparam int FRAC_BITS      = 12;
    localparam int NUM_STATES_W   = 9;
    localparam int CFG_W          = 24;
    localparam int LSE_SIZE       = 32;
    localparam int LSE_IDX_W      = 5;
    localparam int DEF_MAX_STATES = 256;

    localparam logic CFG_SKIP_PENALTY = 1'b0;
    localparam logic CFG_NUM_STATES   = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
    localparam val_t VAL_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});

    // round(65536 * ln(1 + exp(-k/4)))
    localparam logic [15:0] LSE_TABLE [LSE_SIZE] = '{
        16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
        16'd8318,  16'd6567,  16'd5170,  16'd4061,  16'd3184,  16'd2493,  16'd1950,  16'd1523,
        16'd1189,  16'd928,   16'd724,   16'd565,   16'd440,   16'd343,   16'd267,   16'd208,
        16'd162,   16'd126,   16'd98,    16'd77,    16'd60,    16'd47,    16'd36,    16'd28
    };

    function automatic val_t sat_add(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

    // correction in Q.FRAC_BITS, rounded from the 16-bit fraction table
    function automatic val_t lse_corr(input logic [LSE_IDX_W-1:0] k);
        logic [63:0] t;
        logic [63:0] r;
        t = {48'd0, LSE_TABLE[k]};
        r = ((t << FRAC_BITS) + 64'd32768) >> 16;
        lse_corr = val_t'(r[VAL_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ctc_log_forward_recurrence.sv =====
// Top level: streaming log-domain CTC forward recurrence with skip penalty.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+------------------------------------
//   s_       | in  | s_valid / s_ready      | s_log_match_value, s_sequence_start
//   m_       | out | m_valid / m_ready      | m_forward_value, m_row_end
//   cfg_     | in  | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
// One word per cycle when num_states >= 4 and m_ready does not stall; a word reaches m_valid
// through the stage 1, 2, 3 and output registers. Rows of 2 or 3 states run slower: a word
// reading the row store waits until stage 3 writes back the same state of the previous row.
// Reset (aresetn low, synchronous) empties the pipeline and restarts at row zero.
// A stall on m_ready freezes all stages; nothing is dropped or repeated.
`default_nettype none

module ctc_log_forward_recurrence
    import ctclfr_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_wr_en,
    input  wire                           cfg_index,
    input  wire        [CFG_W-1:0]        cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [VAL_W-1:0]        s_log_match_value,
    input  wire                           s_sequence_start,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [VAL_W-1:0]       m_forward_value,
    output logic                          m_row_end
);

    localparam int IDXW = (MAX_STATES > 2) ? $clog2(MAX_STATES) : 1;
    localparam int NW   = (IDXW + 1 > NUM_STATES_W) ? IDXW + 1 : NUM_STATES_W;
    localparam logic [NW-1:0] MAX_N    = NW'(MAX_STATES);
    localparam logic [NW-1:0] RST_LAST = NW'(((MAX_STATES < 256) ? MAX_STATES : 256) - 1);

    // configuration
    val_t            skip_penalty_reg;
    logic [NW-1:0]   last_state_reg;
    logic [NW-1:0]   n_ext;
    logic [NW-1:0]   n_eff;

    // row sequencing
    logic [IDXW-1:0] idx_reg;
    logic            first_reg;
    val_t            bound_reg;
    val_t            init_reg;

    logic [IDXW-1:0] cur_idx;
    logic            cur_first;
    val_t            cur_bound;
    val_t            cur_init;
    logic            cur_last;
    logic            hazard;
    logic            advance;
    logic            accept;

    // stage 1
    logic            v1_reg;
    logic [IDXW-1:0] idx1_reg;
    logic            first1_reg;
    logic            zero1_reg;
    logic            last1_reg;
    val_t            init1_reg;
    val_t            bound1_reg;
    val_t            match1_reg;
    val_t            rdata_reg;
    val_t            left_reg;
    val_t            old_here;
    val_t            old_left;
    val_t            sum_a;
    val_t            sum_b;

    // stage 2
    logic            v2_reg;
    logic [IDXW-1:0] idx2_reg;
    logic            last2_reg;
    val_t            a2_reg;
    val_t            b2_reg;
    logic            a_gt;
    val_t            hi;
    val_t            lo;
    logic [VAL_W-1:0] diff;
    logic [VAL_W-1:0] k_full;

    // stage 3
    logic            v3_reg;
    logic [IDXW-1:0] idx3_reg;
    logic            last3_reg;
    val_t            hi3_reg;
    logic [LSE_IDX_W-1:0] k3_reg;
    logic            far3_reg;
    val_t            corr;
    val_t            f_val;

    // output register
    logic            m_valid_reg;
    val_t            m_value_reg;
    logic            m_row_end_reg;

    val_t            row_store [MAX_STATES];

    // ---------------- configuration ----------------
    always_comb begin
        n_ext = NW'(cfg_wdata[NUM_STATES_W-1:0]);
        if (n_ext < NW'(2)) begin
            n_eff = NW'(2);
        end else if (n_ext > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = n_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_penalty_reg <= '0;
            last_state_reg   <= RST_LAST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SKIP_PENALTY: skip_penalty_reg <= val_t'(cfg_wdata[VAL_W-1:0]);
                CFG_NUM_STATES:   last_state_reg   <= n_eff - NW'(1);
            endcase
        end
    end

    // ---------------- input side ----------------
    always_comb begin
        cur_idx   = s_sequence_start ? '0 : idx_reg;
        cur_first = s_sequence_start ? 1'b1 : first_reg;
        cur_bound = s_sequence_start ? '0 : bound_reg;
        cur_init  = s_sequence_start ? '0 : init_reg;
        cur_last  = (NW'(cur_idx) >= last_state_reg);
        // previous row's write to this state still in flight
        hazard    = !cur_first &&
                    ((v1_reg && (idx1_reg == cur_idx)) ||
                     (v2_reg && (idx2_reg == cur_idx)) ||
                     (v3_reg && (idx3_reg == cur_idx)));
        advance   = !m_valid_reg || m_ready;
        s_ready   = advance && !hazard;
        accept    = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
            bound_reg <= '0;
            init_reg  <= '0;
        end else if (accept) begin
            if (cur_last) begin
                idx_reg   <= '0;
                first_reg <= 1'b0;
                bound_reg <= sat_add(cur_bound, skip_penalty_reg);
                init_reg  <= '0;
            end else begin
                idx_reg   <= cur_idx + IDXW'(1);
                first_reg <= cur_first;
                bound_reg <= cur_bound;
                init_reg  <= sat_add(cur_init, skip_penalty_reg);
            end
        end
    end

    // ---------------- row store ----------------
    always_ff @(posedge aclk) begin
        if (advance && v3_reg) begin
            row_store[idx3_reg] <= f_val;
        end
        if (accept) begin
            rdata_reg <= row_store[cur_idx];
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: match sums ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx1_reg   <= cur_idx;
            first1_reg <= cur_first;
            zero1_reg  <= (cur_idx == '0);
            last1_reg  <= cur_last;
            init1_reg  <= cur_init;
            bound1_reg <= cur_bound;
            match1_reg <= s_log_match_value;
        end
    end

    always_comb begin
        old_here = first1_reg ? init1_reg : rdata_reg;
        old_left = zero1_reg ? bound1_reg : left_reg;
        sum_a    = sat_add(old_here, match1_reg);
        sum_b    = sat_add(old_left, match1_reg);
    end

    always_ff @(posedge aclk) begin
        if (advance && v1_reg) begin
            left_reg  <= old_here;
            a2_reg    <= sum_a;
            b2_reg    <= sum_b;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---------------- stage 2: max and table index ----------------
    always_comb begin
        a_gt   = (a2_reg > b2_reg);
        hi     = a_gt ? a2_reg : b2_reg;
        lo     = a_gt ? b2_reg : a2_reg;
        // hi >= lo, so the difference fits in VAL_W unsigned bits
        diff   = hi - lo;
        k_full = diff >> (FRAC_BITS - 2);
    end

    always_ff @(posedge aclk) begin
        if (advance && v2_reg) begin
            hi3_reg   <= hi;
            k3_reg    <= k_full[LSE_IDX_W-1:0];
            far3_reg  <= |k_full[VAL_W-1:LSE_IDX_W];
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    // ---------------- stage 3: correction and sum ----------------
    always_comb begin
        corr  = far3_reg ? '0 : lse_corr(k3_reg);
        f_val = sat_add(hi3_reg, corr);
    end

    always_ff @(posedge aclk) begin
        if (advance && v3_reg) begin
            m_value_reg   <= f_val;
            m_row_end_reg <= last3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_forward_value = m_value_reg;
    assign m_row_end       = m_row_end_reg;

endmodule

`default_nettype wire

// ===== sv/ctclfr_checker.sv =====
// Port-level checker for the CTC log forward recurrence, bound to the top level.
`default_nettype none

module ctclfr_checker
    import ctclfr_pkg::*;
(
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_valid,
    input wire                    s_ready,
    input wire                    m_valid,
    input wire                    m_ready,
    input wire signed [VAL_W-1:0] m_forward_value,
    input wire                    m_row_end
);

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_forward_value) && $stable(m_row_end))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (inflight_reg != 3'd0))
        else $error("output word without an accepted input word");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

endmodule

bind ctc_log_forward_recurrence ctclfr_checker u_ctclfr_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the CTC log forward recurrence: directed table, random rows, predictor.
`timescale 1ns / 1ps

module tb_top
    import ctclfr_pkg::*;
();

    localparam int DEPTH     = DEF_MAX_STATES;
    localparam int WDOG_MAX  = 4000;
    localparam int DRAIN_CYC = 8;
    localparam bit DO_WORD   = 1'b0;
    localparam bit DO_CFG    = 1'b1;

    // round(65536 * ln(1 + exp(-k/4))), k = 0 .. 31
    localparam int unsigned LN1P_Q16 [32] = '{
        45426, 37745, 31069, 25354, 20530, 16510, 13200, 10500,
        8318, 6567, 5170, 4061, 3184, 2493, 1950, 1523,
        1189, 928, 724, 565, 440, 343, 267, 208,
        162, 126, 98, 77, 60, 47, 36, 28
    };

    typedef struct packed {
        bit             is_cfg;
        logic           idx;
        logic [CFG_W-1:0] data;
        val_t           match;
        logic           start;
        bit             has_exp;
        val_t           exp_val;
        logic           exp_end;
    } step_t;

    typedef struct packed {
        val_t value;
        logic row_end;
    } alpha_t;

    localparam int DIR_LEN = 33;
    localparam step_t DIR_TAB [DIR_LEN] = '{
        '{DO_WORD, 1'b0, 24'd0, 24'sd0,     1'b1, 1'b1, 24'sd2839, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, VAL_MAX,    1'b1, 1'b1, VAL_MAX,   1'b0},
        '{DO_WORD, 1'b0, 24'd0, VAL_MIN,    1'b1, 1'b1, -24'sd8385769, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd2839, 1'b1, 1'b1, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd100,   1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_CFG, CFG_NUM_STATES,   24'd0,        24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_CFG, CFG_SKIP_PENALTY, 24'hFFF000,   24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd4096,  1'b1, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd1000, 1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd5000,  1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd0,     1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_CFG, CFG_NUM_STATES,   24'd511,      24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd7,     1'b1, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd7,    1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_CFG, CFG_NUM_STATES,   24'd4,        24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd1234,  1'b1, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd50000, 1'b0, 1'b0, 24'sd0,   1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd300000, 1'b0, 1'b0, 24'sd0,   1'b0},
        '{DO_CFG, CFG_NUM_STATES,   24'd2,        24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd42,    1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, VAL_MAX,    1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, VAL_MIN,    1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_CFG, CFG_NUM_STATES,   24'd1,        24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_CFG, CFG_SKIP_PENALTY, 24'h7FFFFF,   24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd2048,  1'b1, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd2048, 1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd1,     1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd1,    1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_CFG, CFG_SKIP_PENALTY, 24'h800000,   24'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd0,     1'b1, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd8000,  1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, -24'sd8000, 1'b0, 1'b0, 24'sd0,    1'b0},
        '{DO_WORD, 1'b0, 24'd0, 24'sd123,   1'b0, 1'b0, 24'sd0,    1'b0}
    };

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    val_t             word_match = '0;
    logic             word_start = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    val_t             m_forward_value;
    logic             m_row_end;

    bit   word_has_exp = 1'b0;
    val_t word_exp_val = '0;
    logic word_exp_end = 1'b0;

    // predictor state
    val_t        row_mem [DEPTH];
    bit          row_written [DEPTH];
    int unsigned pos = 0;
    val_t        left_prev = '0;
    val_t        bound_acc = '0;
    val_t        init_acc = '0;
    bit          first_row = 1'b1;
    val_t        penalty = '0;
    logic [8:0]  n_states = 9'd256;

    alpha_t alpha_q[$];
    alpha_t want, got;
    val_t   pred_val;
    logic   pred_end;
    int     words_in = 0;
    int     errs = 0;
    int     stuck = 0;
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;

    ctc_log_forward_recurrence uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_log_match_value (word_match),
        .s_sequence_start  (word_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_forward_value   (m_forward_value),
        .m_row_end         (m_row_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic val_t clamp24(input longint x);
        if (x > longint'(VAL_MAX)) return VAL_MAX;
        if (x < longint'(VAL_MIN)) return VAL_MIN;
        return val_t'(x);
    endfunction

    function automatic val_t log_sum(input val_t a, input val_t b);
        val_t   hi;
        val_t   lo;
        longint d;
        longint c;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        d  = longint'(hi) - longint'(lo);
        c  = 0;
        if ((d >> (FRAC_BITS - 2)) < 32) begin
            c = ((longint'(LN1P_Q16[d >> (FRAC_BITS - 2)]) << FRAC_BITS) + 32768) >> 16;
        end
        return clamp24(longint'(hi) + c);
    endfunction

    function void step_alpha(input val_t m, input logic start, output val_t f, output logic last);
        int unsigned n;
        int unsigned i;
        val_t        here;
        val_t        left;
        n = n_states;
        if (n < 2) n = 2;
        if (n > DEPTH) n = DEPTH;
        if (start) begin
            pos       = 0;
            bound_acc = '0;
            init_acc  = '0;
            first_row = 1'b1;
        end
        i    = pos % DEPTH;
        here = first_row ? init_acc : row_mem[i];
        left = (i == 0) ? bound_acc : left_prev;
        f    = log_sum(clamp24(longint'(here) + longint'(m)),
                       clamp24(longint'(left) + longint'(m)));
        left_prev      = here;
        row_mem[i]     = f;
        row_written[i] = 1'b1;
        init_acc       = clamp24(longint'(init_acc) + longint'(penalty));
        last           = (i >= n - 1);
        if (last) begin
            pos       = 0;
            first_row = 1'b0;
            init_acc  = '0;
            bound_acc = clamp24(longint'(bound_acc) + longint'(penalty));
        end else begin
            pos = i + 1;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SKIP_PENALTY) begin
                    penalty = val_t'(cfg_wdata);
                end else begin
                    n_states = cfg_wdata[8:0];
                end
            end
            if (s_valid && s_ready) begin
                step_alpha(word_match, word_start, pred_val, pred_end);
                if (word_has_exp) begin
                    alpha_q.push_back('{word_exp_val, word_exp_end});
                end else begin
                    alpha_q.push_back('{pred_val, pred_end});
                end
                words_in++;
            end
            if (m_valid && m_ready) begin
                got = '{m_forward_value, m_row_end};
                if (alpha_q.size() == 0) begin
                    $display("%0t: unexpected word value=%0d row_end=%0b",
                             $time, got.value, got.row_end);
                    errs++;
                end else begin
                    want = alpha_q.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: forward_value expected %0d actual %0d",
                                 $time, want.value, got.value);
                        errs++;
                    end
                    if (got.row_end !== want.row_end) begin
                        $display("%0t: row_end expected %0b actual %0b",
                                 $time, want.row_end, got.row_end);
                        errs++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            stuck <= 0;
        end else if (stuck >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic push_word(input val_t m, input logic start, input bit hx, input val_t xv,
                             input logic xe);
        int seen;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        word_match   = m;
        word_start   = start;
        word_has_exp = hx;
        word_exp_val = xv;
        word_exp_end = xe;
        s_valid      = 1'b1;
        seen         = words_in;
        do @(negedge aclk); while (words_in == seen);
    endtask

    task automatic drain_all();
        s_valid = 1'b0;
        while (alpha_q.size() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
        drain_all();
        repeat (DRAIN_CYC) @(negedge aclk);
        cfg_index = idx;
        cfg_wdata = data;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic val_t rand_match();
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return val_t'($urandom);
            default: return val_t'(int'($urandom_range(65535)) - 32768);
        endcase
    endfunction

    initial begin
        int          neff;
        int          count;
        int          noise;
        logic        start;
        logic [8:0]  ns;
        logic [23:0] pen;
        for (int k = 0; k < DEPTH; k++) begin
            row_mem[k]     = '0;
            row_written[k] = 1'b0;
        end
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int j = 0; j < DIR_LEN; j++) begin
            if (DIR_TAB[j].is_cfg) begin
                cfg_write(DIR_TAB[j].idx, DIR_TAB[j].data);
            end else begin
                push_word(DIR_TAB[j].match, DIR_TAB[j].start, DIR_TAB[j].has_exp,
                          DIR_TAB[j].exp_val, DIR_TAB[j].exp_end);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       begin ns = 9'd2;   pen = 24'h800000; end
                1:       begin ns = 9'd256; pen = 24'h000000; end
                2:       begin ns = 9'd3;   pen = 24'hFFF000; end
                3:       begin ns = 9'd1;   pen = 24'h7FFFFF; end
                4:       begin ns = 9'd4;   pen = 24'($urandom); end
                5:       begin ns = 9'($urandom_range(16, 5));
                               pen = 24'(-int'($urandom_range(65535))); end
                6:       begin ns = 9'd0;   pen = 24'(-int'($urandom_range(800))); end
                default: begin ns = 9'($urandom_range(40, 2)); pen = 24'h800000; end
            endcase
            cfg_write(CFG_NUM_STATES, {15'd0, ns});
            cfg_write(CFG_SKIP_PENALTY, pen);
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            neff  = (ns < 2) ? 2 : (ns > DEPTH) ? DEPTH : int'(ns);
            count = (neff >= 200) ? neff + 10 : 70;
            noise = (neff >= 200) ? 0 : 2;
            for (int k = 0; k < count; k++) begin
                if (ph == 2 && k == 30) drain_all();
                start = ($urandom_range(99) < noise);
                // never let a row read a store entry that was never written
                if (!first_row && !row_written[pos % DEPTH]) start = 1'b1;
                push_word(rand_match(), start, 1'b0, '0, 1'b0);
            end
        end

        drain_all();
        repeat (20) @(negedge aclk);
        if (errs == 0 && alpha_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ctclfr_pkg.sv
sv/ctc_log_forward_recurrence.sv
sv/ctclfr_checker.sv
bench/tb_top.sv
